[src/fat32_volume_file_locator_unit_defines.svh]
// ----------------------------------------------------------------------------
// FAT32 volume file locator: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FAT32_VOLUME_FILE_LOCATOR_UNIT_DEFINES_SVH
`define FAT32_VOLUME_FILE_LOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FVFL_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fvfl: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FVFL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fvfl: next-cycle check failed");

`endif

[src/fvfl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 volume file locator package
// Beat types, sector kind codes and fixed field offsets of the parsed sectors.
// ----------------------------------------------------------------------------
package fvfl_pkg;

  // Sector geometry.
  localparam int unsigned SectorBytes = 512;
  localparam int unsigned SectorShift = 9;

  // Sector kind codes; result kinds use the same encoding.
  localparam logic [1:0] KIND_MBR  = 2'd0;
  localparam logic [1:0] KIND_BOOT = 2'd1;
  localparam logic [1:0] KIND_DIR  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Byte offsets within the sectors.
  localparam logic [8:0] MBR_PART_START  = 9'd454;
  localparam logic [8:0] MBR_PART_END    = 9'd457;
  localparam logic [8:0] BOOT_BPS_LO     = 9'd11;
  localparam logic [8:0] BOOT_BPS_HI     = 9'd12;
  localparam logic [8:0] BOOT_SPC        = 9'd13;
  localparam logic [8:0] BOOT_RSVD_LO    = 9'd14;
  localparam logic [8:0] BOOT_RSVD_HI    = 9'd15;
  localparam logic [8:0] BOOT_NFATS      = 9'd16;
  localparam logic [8:0] BOOT_FATSZ_LO   = 9'd36;
  localparam logic [8:0] BOOT_FATSZ_HI   = 9'd39;
  localparam logic [8:0] BOOT_ROOT_LO    = 9'd44;
  localparam logic [8:0] BOOT_ROOT_HI    = 9'd47;
  localparam logic [8:0] DIR_FIRST_ENTRY = 9'd20;
  localparam logic [8:0] DIR_CAPTURE_LEN = 9'd11;
  localparam logic [8:0] LAST_BYTE       = 9'd511;

  // Offsets inside one directory entry window.
  localparam logic [8:0] ENT_CLUS_HI_LO = 9'd0;
  localparam logic [8:0] ENT_CLUS_HI_HI = 9'd1;
  localparam logic [8:0] ENT_CLUS_LO_LO = 9'd6;
  localparam logic [8:0] ENT_CLUS_LO_HI = 9'd7;
  localparam logic [8:0] ENT_SIZE_LO    = 9'd8;
  localparam logic [8:0] ENT_SIZE_HI    = 9'd11;

  typedef struct packed {
    logic [1:0] req_type;
    logic [8:0] byte_index;
    logic [7:0] data_byte;
    logic [3:0] entry_slot;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] read_address;
    logic [23:0] file_sectors;
    logic        entries_ended;
    logic        bad_sector_size;
  } out_beat_t;

endpackage

[src/fvfl_chan_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 volume file locator channel
// Valid/ready channel carrying one beat of the given payload type.
// ----------------------------------------------------------------------------
interface fvfl_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/fat32_volume_file_locator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 volume file locator
// Captures MBR, boot sector and directory entry fields from a byte stream and
// gives the next card address to read at the end of each sector.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload      Beat
//  in_i     sink       in_beat_t    one sector byte with kind, index and slot
//  out_o    source     out_beat_t   one result per byte 511 of a known kind
//  cfg      write-only 1 bit        block addressing enable
//
// One byte is accepted per cycle unless the output stalls; fields are captured
// at the accepting edge. A result for a taken byte 511 then passes the three
// register stages s1, s2 and out, around the two 32x8 multipliers and adds.
// Reset clears all captured fields, the pipeline valids and the config register.
// A stalled output holds the whole pipeline and drops in_i.ready.
// ----------------------------------------------------------------------------
module fat32_volume_file_locator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  fvfl_chan_if.sink    in_i,
  fvfl_chan_if.source  out_o
);
  import fvfl_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] base;
    logic [23:0] fsec;
    logic        ended;
    logic        bad;
  } stage_t;

  // Configuration and captured fields.
  logic        block_addr_q;
  logic [31:0] partition_start_q, partition_start_d;
  logic [15:0] sector_size_q, sector_size_d;
  logic [7:0]  cluster_sectors_q, cluster_sectors_d;
  logic [15:0] reserved_count_q, reserved_count_d;
  logic [7:0]  fat_copies_q, fat_copies_d;
  logic [31:0] fat_length_q, fat_length_d;
  logic [31:0] root_cluster_q, root_cluster_d;
  logic [31:0] entry_cluster_q, entry_cluster_d;
  logic [31:0] entry_size_q, entry_size_d;
  logic [31:0] data_region_q;

  // Pipeline.
  logic        s1_valid_q, s2_valid_q, out_valid_q;
  stage_t      s1_q, s2_q, s1_d;
  logic [31:0] s1_fat_prod_q, s1_part_q;
  logic [15:0] s1_rsvd_q;
  out_beat_t   out_q, out_d;

  logic        en, acc, res_hit;
  logic [1:0]  kind;
  logic [8:0]  idx;
  logic [7:0]  dbyte;
  logic [8:0]  mbr_off, ent_base, ent_off;
  logic [1:0]  sz_lane;
  logic [31:0] clus, rel;
  logic [39:0] clus_prod, fat_prod;
  logic [31:0] drs_new, sum;

  assign en    = !out_valid_q || out_o.ready;
  assign acc   = in_i.valid && en;
  assign kind  = in_i.data.req_type;
  assign idx   = in_i.data.byte_index;
  assign dbyte = in_i.data.data_byte;

  assign in_i.ready = en;

  // Offsets relative to the MBR partition entry and the chosen directory entry.
  assign mbr_off  = idx - MBR_PART_START;
  assign ent_base = {in_i.data.entry_slot, 5'b00000} + DIR_FIRST_ENTRY;
  assign ent_off  = idx - ent_base;
  assign sz_lane  = 2'(ent_off - ENT_SIZE_LO);

  // Field capture, little-endian, one byte per beat.
  always_comb begin
    partition_start_d = partition_start_q;
    sector_size_d     = sector_size_q;
    cluster_sectors_d = cluster_sectors_q;
    reserved_count_d  = reserved_count_q;
    fat_copies_d      = fat_copies_q;
    fat_length_d      = fat_length_q;
    root_cluster_d    = root_cluster_q;
    entry_cluster_d   = entry_cluster_q;
    entry_size_d      = entry_size_q;
    if (acc) begin
      case (kind)
        KIND_MBR: begin
          if (idx >= MBR_PART_START && idx <= MBR_PART_END) begin
            partition_start_d[{mbr_off[1:0], 3'b000} +: 8] = dbyte;
          end
        end
        KIND_BOOT: begin
          case (idx) inside
            BOOT_BPS_LO:                     sector_size_d[7:0]     = dbyte;
            BOOT_BPS_HI:                     sector_size_d[15:8]    = dbyte;
            BOOT_SPC:                        cluster_sectors_d      = dbyte;
            BOOT_RSVD_LO:                    reserved_count_d[7:0]  = dbyte;
            BOOT_RSVD_HI:                    reserved_count_d[15:8] = dbyte;
            BOOT_NFATS:                      fat_copies_d           = dbyte;
            [BOOT_FATSZ_LO:BOOT_FATSZ_HI]: fat_length_d[{idx[1:0], 3'b000} +: 8] = dbyte;
            [BOOT_ROOT_LO:BOOT_ROOT_HI]:   root_cluster_d[{idx[1:0], 3'b000} +: 8] = dbyte;
            default: ;
          endcase
        end
        KIND_DIR: begin
          if (idx >= ent_base && ent_off <= DIR_CAPTURE_LEN) begin
            case (ent_off) inside
              ENT_CLUS_HI_LO:              entry_cluster_d[23:16] = dbyte;
              ENT_CLUS_HI_HI:              entry_cluster_d[31:24] = dbyte;
              ENT_CLUS_LO_LO:              entry_cluster_d[7:0]   = dbyte;
              ENT_CLUS_LO_HI:              entry_cluster_d[15:8]  = dbyte;
              [ENT_SIZE_LO:ENT_SIZE_HI]: entry_size_d[{sz_lane, 3'b000} +: 8] = dbyte;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // First stage: cluster offset and FAT area products from the captured fields.
  assign res_hit   = acc && (kind != KIND_NONE) && (idx == LAST_BYTE);
  assign clus      = (kind == KIND_BOOT) ? root_cluster_q : entry_cluster_q;
  assign rel       = clus - 32'd2;
  assign clus_prod = rel * cluster_sectors_q;
  assign fat_prod  = fat_length_q * fat_copies_q;

  always_comb begin
    s1_d.kind  = kind;
    s1_d.base  = (kind == KIND_MBR) ? partition_start_q : clus_prod[31:0];
    s1_d.fsec  = (kind == KIND_DIR) ? 24'(entry_size_d >> SectorShift) + 24'd1 : 24'd0;
    s1_d.ended = (kind == KIND_DIR) && (entry_cluster_q == 32'd0);
    s1_d.bad   = (kind == KIND_BOOT) && (sector_size_q != 16'(SectorBytes));
  end

  // Second stage: start of the data region.
  assign drs_new = s1_part_q + s1_fat_prod_q + {16'b0, s1_rsvd_q};

  // Output stage: add the region start for non-MBR results and, without block addressing, scale to a byte address.
  always_comb begin
    sum = s2_q.base + ((s2_q.kind == KIND_MBR) ? 32'd0 : data_region_q)
        + ((s2_q.kind == KIND_DIR) ? 32'd1 : 32'd0);
    out_d.result_kind     = s2_q.kind;
    out_d.read_address    = block_addr_q ? sum : (sum << SectorShift);
    out_d.file_sectors    = s2_q.fsec;
    out_d.entries_ended   = s2_q.ended;
    out_d.bad_sector_size = s2_q.bad;
  end

  // Control and captured state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_addr_q      <= 1'b0;
      partition_start_q <= '0;
      sector_size_q     <= '0;
      cluster_sectors_q <= '0;
      reserved_count_q  <= '0;
      fat_copies_q      <= '0;
      fat_length_q      <= '0;
      root_cluster_q    <= '0;
      entry_cluster_q   <= '0;
      entry_size_q      <= '0;
      data_region_q     <= '0;
      s1_valid_q        <= 1'b0;
      s2_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        block_addr_q <= cfg_wdata_i;
      end
      partition_start_q <= partition_start_d;
      sector_size_q     <= sector_size_d;
      cluster_sectors_q <= cluster_sectors_d;
      reserved_count_q  <= reserved_count_d;
      fat_copies_q      <= fat_copies_d;
      fat_length_q      <= fat_length_d;
      root_cluster_q    <= root_cluster_d;
      entry_cluster_q   <= entry_cluster_d;
      entry_size_q      <= entry_size_d;
      if (en) begin
        if (s1_valid_q && s1_q.kind == KIND_BOOT) begin
          data_region_q <= drs_new;
        end
        s1_valid_q  <= res_hit;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q          <= s1_d;
      s1_fat_prod_q <= fat_prod[31:0];
      s1_part_q     <= partition_start_q;
      s1_rsvd_q     <= reserved_count_q;
      s2_q          <= s1_q;
      out_q         <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

[src/fvfl_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 volume file locator port checker
// Watches the channel ports of the locator for stall and result field rules.
// ----------------------------------------------------------------------------
`include "fat32_volume_file_locator_unit_defines.svh"

module fvfl_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input fvfl_pkg::out_beat_t out_data_i
);
  import fvfl_pkg::*;

  // A result that is not taken stays unchanged.
  `FVFL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_data_i))

  // While a result waits, no new byte is taken.
  `FVFL_ASSERT_SAME(a_in_blocked, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

  // File size and end of entries belong to directory results only.
  `FVFL_ASSERT_SAME(a_dir_fields, clk_i, rst_ni,
                    out_valid_i && out_data_i.result_kind != KIND_DIR,
                    out_data_i.file_sectors == 24'd0 && !out_data_i.entries_ended)

  // The sector size flag belongs to volume results only.
  `FVFL_ASSERT_SAME(a_bad_size, clk_i, rst_ni,
                    out_valid_i && out_data_i.result_kind != KIND_BOOT,
                    !out_data_i.bad_sector_size)

endmodule

bind fat32_volume_file_locator_unit fvfl_chk u_fvfl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
